FILE: sv/rx_frame_deframer_crc16_assert.svh
// ----------------------------------------------------------------------------
// rx_frame_deframer_crc16 assertion macros
// Shared property templates; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef RX_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define RX_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// Same-cycle implication.
`define RFD_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, constants and the CRC-16/XMODEM byte step of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 128;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_TOPBIT   = 16'h8000;
  localparam logic [15:0] CRC_INIT     = 16'h0000;
  localparam int unsigned LEN_HARD_MAX = 128;
  localparam logic [7:0]  LEN_MIN      = 8'd10;

  // Byte positions inside a frame
  localparam logic [7:0] POS_HDR     = 8'd0;
  localparam logic [7:0] POS_TYPE    = 8'd3;
  localparam logic [7:0] POS_SEQ1    = 8'd4;
  localparam logic [7:0] POS_SEQ2    = 8'd5;
  localparam logic [7:0] POS_LEN     = 8'd7;
  localparam logic [7:0] POS_CRC_HI  = 8'd8;
  localparam logic [7:0] POS_CRC_LO  = 8'd9;
  localparam logic [7:0] POS_PAYLOAD = 8'd10;

  localparam int unsigned CHUNK_BYTES = 8;

  // Register indexes on the APB port
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  typedef enum logic [1:0] {
    EV_HDR    = 2'd0,
    EV_CHUNK  = 2'd1,
    EV_REJECT = 2'd2,
    EV_BADLEN = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_LD,
    ST_LEN_EVAL,
    ST_CRC,
    ST_DECIDE,
    ST_CHUNK,
    ST_EMIT
  } state_e;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rfd_ram.sv
// ----------------------------------------------------------------------------
// rfd_ram
// Generic single-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rx_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// rx_frame_deframer_crc16
// Serial-line receive deframer with CRC-16/XMODEM check and payload chunking.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one received byte per word (rx_byte_i, rx_valid_i/rx_ready_o).
//   out channel: result words (event, frame fields, CRC, 8-byte payload chunk,
//   last flag) on out_valid_o/out_ready_i; last marks the final result word
//   caused by one received byte.
//   APB port: register 0 header_byte at 0x0, register 1 max_frame_len at 0x4.
// Processing:
//   A byte that decides nothing leaves the sequencer idle; once eight bytes
//   are held, the length byte is read from the window RAM first. A decided
//   frame is read back byte by byte for the CRC pass and its verdict word,
//   then again for each payload chunk. The byte-serial CRC pass and the single
//   read port of the window RAM set the processing time; out stalls add to it.
// Reset:
//   Window empty, registers at their defaults. The window RAM is not cleared;
//   only written entries are ever read.
// Stall:
//   A pending result word holds in the output register; the sequencer waits
//   for it to drain before loading the next one. rx_ready_o is high only while
//   the sequencer is idle, which may be while a result word still waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rx_frame_deframer_crc16_assert.svh"

module rx_frame_deframer_crc16
  import rfd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received byte stream
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  // result words
  output logic [1:0]       event_res_o,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       seq_first_o,
  output logic [7:0]       seq_second_o,
  output logic [7:0]       frame_len_o,
  output logic [15:0]      crc_calc_o,
  output logic [63:0]      chunk_data_o,
  output logic [3:0]       chunk_bytes_o,
  output logic             last_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LIM = (WINDOW_DEPTH < LEN_HARD_MAX) ? WINDOW_DEPTH : LEN_HARD_MAX;
  localparam logic [AW:0] DEPTH_W = (AW+1)'(WINDOW_DEPTH);
  localparam logic [7:0]  LIM_W   = 8'(LIM);

  // Map a logical sum onto a ring slot; the sum stays below twice the depth.
  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
    return r[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] hdr_q, maxlen_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= 8'hA5;
      maxlen_q <= 8'(LEN_HARD_MAX);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_HEADER: hdr_q    <= pwdata[7:0];
        REG_MAXLEN: maxlen_q <= pwdata[7:0];
        default:    hdr_q    <= hdr_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEADER: prdata = {24'h0, hdr_q};
      REG_MAXLEN: prdata = {24'h0, maxlen_q};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  start_q, start_d;
  logic [7:0]     len_q, len_d;
  logic [15:0]    crc_q, crc_d;
  logic [7:0]     b0_q, b0_d, ty_q, ty_d, s1_q, s1_d, s2_q, s2_d;
  logic [15:0]    ref_q, ref_d;
  logic [7:0]     iss_q, iss_d;
  logic           pend_q, pend_d;
  logic [7:0]     pidx_q, pidx_d;
  logic [3:0]     cb_q, cb_d, cf_q, cf_d;
  logic [63:0]    chunk_q, chunk_d;

  // output register
  logic           out_valid_q;
  event_e         ev_q, ev_d;
  logic [7:0]     oty_q, oty_d, os1_q, os1_d, os2_q, os2_d, olen_q, olen_d;
  logic [15:0]    ocrc_q, ocrc_d;
  logic [63:0]    odata_q, odata_d;
  logic [3:0]     onb_q, onb_d;
  logic           olast_q, olast_d;
  logic           emit;

  // window RAM port
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_rdata;

  rfd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared decisions
  // --------------------------------------------------------------------------
  logic           rx_acc, win_full, noise;
  logic [CW-1:0]  base_count, new_count;
  logic [AW-1:0]  base_start;
  logic [7:0]     emax;
  logic           bad_len, frame_ready, crc_done, frame_ok;
  logic           out_free, crc_issue, chunk_issue, chunk_last;

  assign rx_ready_o  = (state_q == ST_IDLE);
  assign rx_acc      = rx_valid_i && rx_ready_o;
  // a full window is dropped before the new byte lands
  assign win_full    = (count_q >= CW'(WINDOW_DEPTH));
  assign base_count  = win_full ? '0 : count_q;
  assign base_start  = win_full ? '0 : start_q;
  assign new_count   = base_count + CW'(1);
  assign noise       = (base_count == '0) && (rx_byte_i != hdr_q);

  assign emax        = (maxlen_q > LIM_W) ? LIM_W : maxlen_q;
  assign bad_len     = (len_q < LEN_MIN) || (len_q > emax);
  assign frame_ready = (9'(count_q) >= 9'(len_q));

  assign out_free    = !out_valid_q || out_ready_i;
  assign crc_issue   = (state_q == ST_CRC) && (iss_q < len_q);
  assign crc_done    = (state_q == ST_CRC) && pend_q && (pidx_q == len_q - 8'd1);
  assign frame_ok    = (b0_q == hdr_q) && (crc_q == ref_q);
  assign chunk_issue = (state_q == ST_CHUNK) && (cb_q < 4'(CHUNK_BYTES)) && (iss_q < len_q);
  assign chunk_last  = (iss_q == len_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (rx_acc && !noise && (new_count >= CW'(8))) begin
          state_d = ST_LEN_RD;
        end
      end
      ST_LEN_RD:   state_d = ST_LEN_LD;
      ST_LEN_LD:   state_d = ST_LEN_EVAL;
      ST_LEN_EVAL: begin
        priority if (bad_len) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (frame_ready) begin
          state_d = ST_CRC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CRC: begin
        if (crc_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (frame_ok && (len_q != LEN_MIN)) begin
            state_d = ST_CHUNK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CHUNK: begin
        if (!chunk_issue && !pend_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = chunk_last ? ST_IDLE : ST_CHUNK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and result words
  // --------------------------------------------------------------------------
  always_comb begin
    count_d  = count_q;
    start_d  = start_q;
    len_d    = len_q;
    crc_d    = crc_q;
    b0_d     = b0_q;
    ty_d     = ty_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    ref_d    = ref_q;
    iss_d    = iss_q;
    pend_d   = 1'b0;
    pidx_d   = iss_q;
    cb_d     = cb_q;
    cf_d     = cf_q;
    chunk_d  = chunk_q;

    ram_we    = 1'b0;
    ram_waddr = wrap_idx((AW+1)'(base_start) + (AW+1)'(base_count));
    ram_re    = 1'b0;
    ram_raddr = wrap_idx((AW+1)'(start_q) + (AW+1)'(iss_q));

    emit    = 1'b0;
    ev_d    = EV_HDR;
    oty_d   = '0;
    os1_d   = '0;
    os2_d   = '0;
    olen_d  = len_q;
    ocrc_d  = '0;
    odata_d = '0;
    onb_d   = '0;
    olast_d = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (rx_acc) begin
          count_d = base_count;
          start_d = base_start;
          if (!noise) begin
            ram_we  = 1'b1;
            count_d = new_count;
          end
        end
      end
      ST_LEN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_idx((AW+1)'(start_q) + (AW+1)'(POS_LEN));
      end
      ST_LEN_LD: begin
        len_d = ram_rdata;
      end
      ST_LEN_EVAL: begin
        iss_d = '0;
        crc_d = CRC_INIT;
        if (bad_len && out_free) begin
          // bad length: clear the window
          emit    = 1'b1;
          ev_d    = EV_BADLEN;
          count_d = '0;
          start_d = '0;
        end
      end
      ST_CRC: begin
        if (crc_issue) begin
          ram_re = 1'b1;
          iss_d  = iss_q + 8'd1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          unique case (pidx_q)
            POS_CRC_HI: ref_d[15:8] = ram_rdata;
            POS_CRC_LO: ref_d[7:0]  = ram_rdata;
            default:    crc_d       = crc16_byte(crc_q, ram_rdata);
          endcase
          if (pidx_q == POS_HDR)  b0_d = ram_rdata;
          if (pidx_q == POS_TYPE) ty_d = ram_rdata;
          if (pidx_q == POS_SEQ1) s1_d = ram_rdata;
          if (pidx_q == POS_SEQ2) s2_d = ram_rdata;
        end
      end
      ST_DECIDE: begin
        iss_d   = POS_PAYLOAD;
        cb_d    = '0;
        cf_d    = '0;
        chunk_d = '0;
        if (out_free) begin
          emit   = 1'b1;
          ocrc_d = crc_q;
          if (!frame_ok) begin
            // drop the oldest byte and wait for more
            ev_d    = EV_REJECT;
            start_d = (start_q == AW'(WINDOW_DEPTH - 1)) ? '0 : start_q + AW'(1);
            count_d = count_q - CW'(1);
          end else begin
            ev_d    = EV_HDR;
            oty_d   = ty_q;
            os1_d   = s1_q;
            os2_d   = s2_q;
            olast_d = (len_q == LEN_MIN);
            if (len_q == LEN_MIN) begin
              count_d = '0;
              start_d = '0;
            end
          end
        end
      end
      ST_CHUNK: begin
        if (chunk_issue) begin
          ram_re = 1'b1;
          iss_d  = iss_q + 8'd1;
          cb_d   = cb_q + 4'd1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          // fill lanes from the top
          for (int j = 0; j < CHUNK_BYTES; j++) begin
            if (cf_q == 4'(j)) begin
              chunk_d[8*(CHUNK_BYTES-1-j) +: 8] = ram_rdata;
            end
          end
          cf_d = cf_q + 4'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          ev_d    = EV_CHUNK;
          oty_d   = ty_q;
          os1_d   = s1_q;
          os2_d   = s2_q;
          ocrc_d  = crc_q;
          odata_d = chunk_q;
          onb_d   = cf_q;
          olast_d = chunk_last;
          cb_d    = '0;
          cf_d    = '0;
          chunk_d = '0;
          if (chunk_last) begin
            count_d = '0;
            start_d = '0;
          end
        end
      end
      default: begin
        count_d = '0;
        start_d = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      start_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      start_q <= start_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    crc_q   <= crc_d;
    b0_q    <= b0_d;
    ty_q    <= ty_d;
    s1_q    <= s1_d;
    s2_q    <= s2_d;
    ref_q   <= ref_d;
    iss_q   <= iss_d;
    pidx_q  <= pidx_d;
    cb_q    <= cb_d;
    cf_q    <= cf_d;
    chunk_q <= chunk_d;
    if (emit) begin
      ev_q    <= ev_d;
      oty_q   <= oty_d;
      os1_q   <= os1_d;
      os2_q   <= os2_d;
      olen_q  <= olen_d;
      ocrc_q  <= ocrc_d;
      odata_q <= odata_d;
      onb_q   <= onb_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign frame_type_o  = oty_q;
  assign seq_first_o   = os1_q;
  assign seq_second_o  = os2_q;
  assign frame_len_o   = olen_q;
  assign crc_calc_o    = ocrc_q;
  assign chunk_data_o  = odata_q;
  assign chunk_bytes_o = onb_q;
  assign last_o        = olast_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RFD_ASSERT_HOLDS(a_count_bound, 1'b1, count_q <= CW'(WINDOW_DEPTH), "window count above depth")
  `RFD_ASSERT_HOLDS(a_chunk_size, out_valid_q && ev_q == EV_CHUNK, onb_q != 4'd0 && onb_q <= 4'(CHUNK_BYTES), "payload chunk size out of range")
  `RFD_ASSERT_HOLDS(a_no_chunk_data, out_valid_q && ev_q != EV_CHUNK, onb_q == 4'd0 && odata_q == 64'h0, "non-chunk word carries payload")
  `RFD_ASSERT_HOLDS(a_pend_src, pend_q, $past(state_q) == ST_CRC || $past(state_q) == ST_CHUNK, "read pending outside a sweep")
  `RFD_ASSERT_NEXT(a_frame_clears, state_q == ST_EMIT && out_free && chunk_last, count_q == '0 && state_q == ST_IDLE, "accepted frame left window data")

endmodule

`default_nettype wire

FILE: sim/rx_frame_deframer_crc16_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_frame_deframer_crc16_tb
// Self-checking bench for the receive deframer. Streams bytes into the rx
// channel: noise, well-formed CRC-16/XMODEM frames, corrupted, truncated and
// badly sized frames. A built-in deframer predicts every result word, and
// each word taken from the out channel is checked against the oldest one
// still due. Phases change header_byte and max_frame_len over the APB port
// and vary the idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module rx_frame_deframer_crc16_tb;
  import rfd_pkg::*;

  localparam int unsigned DEPTH         = 128;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  ftype;
    logic [7:0]  seq1;
    logic [7:0]  seq2;
    logic [7:0]  flen;
    logic [15:0] crc;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } frame_rec_t;

  // Drive every block input to a known value from time zero.
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        rx_valid_i  = 1'b0;
  logic        rx_ready_o;
  logic [1:0]  event_res_o;
  logic [7:0]  frame_type_o;
  logic [7:0]  seq_first_o;
  logic [7:0]  seq_second_o;
  logic [7:0]  frame_len_o;
  logic [15:0] crc_calc_o;
  logic [63:0] chunk_data_o;
  logic [3:0]  chunk_bytes_o;
  logic        last_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = 3'b000;
  logic [31:0] pwdata      = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Bytes waiting to be sent, and result words the deframer owes us.
  logic [7:0]  rx_bytes_q[$];
  frame_rec_t  records_due[$];

  // Shadow deframer state: circular byte window and the two registers.
  logic [7:0]  win_mem [DEPTH];
  logic [6:0]  win_head   = 7'd0;
  int unsigned win_cnt    = 0;
  logic [7:0]  cfg_hdr    = 8'hA5;
  logic [7:0]  cfg_maxlen = 8'd128;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt   = 0;

  rx_frame_deframer_crc16 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .event_res_o   (event_res_o),
    .frame_type_o  (frame_type_o),
    .seq_first_o   (seq_first_o),
    .seq_second_o  (seq_second_o),
    .frame_len_o   (frame_len_o),
    .crc_calc_o    (crc_calc_o),
    .chunk_data_o  (chunk_data_o),
    .chunk_bytes_o (chunk_bytes_o),
    .last_o        (last_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // CRC-16/XMODEM, one data bit at a time, MSB first.
  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [7:0] win_at(input int unsigned i);
    return win_mem[win_head + 7'(i)];
  endfunction

  function automatic frame_rec_t mk_rec(input event_e ev, input logic [7:0] ftype,
                                        input logic [7:0] seq1, input logic [7:0] seq2,
                                        input logic [7:0] flen, input logic [15:0] crc,
                                        input logic [63:0] data, input logic [3:0] nbytes,
                                        input logic last);
    frame_rec_t r;
    r.ev     = ev;
    r.ftype  = ftype;
    r.seq1   = seq1;
    r.seq2   = seq2;
    r.flen   = flen;
    r.crc    = crc;
    r.data   = data;
    r.nbytes = nbytes;
    r.last   = last;
    return r;
  endfunction

  // Append one result word to the list of words still due.
  function automatic void owe_rec(input frame_rec_t r);
    records_due = {records_due, r};
  endfunction

  // Append one byte to the send list.
  function automatic void stage_byte(input logic [7:0] b);
    rx_bytes_q = {rx_bytes_q, b};
  endfunction

  // Take one received byte into the shadow window and queue the result words
  // it causes.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0]  flen, ftype, s1, s2;
    logic [15:0] crc;
    logic [63:0] data;
    int unsigned lim, pay, pos, nb;
    // A full window restarts from empty; normal traffic never gets here.
    if (win_cnt >= DEPTH) begin
      win_cnt  = 0;
      win_head = 7'd0;
    end
    // Drop noise while no frame is open.
    if (win_cnt == 0 && b != cfg_hdr) return;
    win_mem[win_head + 7'(win_cnt)] = b;
    win_cnt++;
    if (win_cnt < 8) return;

    flen = win_at(POS_LEN);
    lim  = (cfg_maxlen > LEN_HARD_MAX) ? LEN_HARD_MAX : cfg_maxlen;
    if (flen < LEN_MIN || flen > lim) begin
      win_cnt  = 0;
      win_head = 7'd0;
      owe_rec(mk_rec(EV_BADLEN, 8'h00, 8'h00, 8'h00, flen, 16'h0000,
                     64'h0, 4'd0, 1'b1));
      return;
    end
    if (win_cnt < flen) return;

    // CRC covers the eight header bytes and the payload, skipping the CRC field.
    crc = CRC_INIT;
    for (int unsigned i = 0; i < 8; i++) crc = crc_xmodem_step(crc, win_at(i));
    for (int unsigned i = POS_PAYLOAD; i < flen; i++) crc = crc_xmodem_step(crc, win_at(i));

    if (win_at(POS_HDR) != cfg_hdr || crc != {win_at(POS_CRC_HI), win_at(POS_CRC_LO)}) begin
      // Slide the window by one byte and retry on the next byte.
      win_head = win_head + 7'd1;
      win_cnt--;
      owe_rec(mk_rec(EV_REJECT, 8'h00, 8'h00, 8'h00, flen, crc,
                     64'h0, 4'd0, 1'b1));
      return;
    end

    ftype = win_at(POS_TYPE);
    s1    = win_at(POS_SEQ1);
    s2    = win_at(POS_SEQ2);
    pay   = flen - POS_PAYLOAD;
    owe_rec(mk_rec(EV_HDR, ftype, s1, s2, flen, crc, 64'h0, 4'd0, pay == 0));
    pos = 0;
    while (pos < pay) begin
      nb   = (pay - pos > CHUNK_BYTES) ? CHUNK_BYTES : pay - pos;
      data = 64'h0;
      for (int unsigned j = 0; j < CHUNK_BYTES; j++)
        data = {data[55:0], (j < nb) ? win_at(POS_PAYLOAD + pos + j) : 8'h00};
      pos += nb;
      owe_rec(mk_rec(EV_CHUNK, ftype, s1, s2, flen, crc, data, 4'(nb),
                     pos >= pay));
    end
    win_cnt  = 0;
    win_head = 7'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  // Queue the first `keep` bytes of a frame with length byte flen and a
  // matching CRC; optionally flip one bit anywhere in it.
  function automatic void push_frame(input logic [7:0] hdr, input int unsigned flen,
                                     input int unsigned keep, input bit corrupt);
    logic [7:0]  fb [256];
    logic [15:0] crc;
    int unsigned spot;
    fb[POS_HDR] = hdr;
    for (int i = 1; i < 256; i++) fb[i] = 8'($urandom);
    fb[POS_LEN] = 8'(flen);
    crc = CRC_INIT;
    for (int unsigned i = 0; i < 8; i++) crc = crc_xmodem_step(crc, fb[i]);
    for (int unsigned i = POS_PAYLOAD; i < flen; i++) crc = crc_xmodem_step(crc, fb[i]);
    fb[POS_CRC_HI] = crc[15:8];
    fb[POS_CRC_LO] = crc[7:0];
    if (corrupt) begin
      spot = $urandom_range(0, flen - 1);
      fb[spot] = fb[spot] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (int unsigned i = 0; i < keep; i++) stage_byte(fb[i]);
  endfunction

  // Mostly sound frames with random content; the rest corrupted, truncated,
  // badly sized, or plain line noise. Noise does not count toward the quota.
  function automatic void push_traffic(input logic [7:0] hdr, input logic [7:0] maxlen,
                                       input int unsigned quota);
    int unsigned lim, top, flen, pick, done;
    lim  = (maxlen > LEN_HARD_MAX) ? LEN_HARD_MAX : maxlen;
    // With a limit below the minimum no length is valid; still vary the lengths.
    top  = (lim < LEN_MIN) ? 24 : lim;
    done = 0;
    while (done < quota) begin
      // Keep most frames short so the slow CRC pass does not dominate.
      pick = $urandom_range(0, 99);
      if (pick < 8) flen = top;
      else if (pick < 25) flen = $urandom_range(LEN_MIN, top);
      else flen = $urandom_range(LEN_MIN, (top < 32) ? top : 32);

      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        push_frame(hdr, flen, flen, 1'b0);
        done += flen;
      end else if (pick < 74) begin
        push_frame(hdr, flen, flen, 1'b1);
        done += flen;
      end else if (pick < 86) begin
        // Length byte out of bounds: at either edge or anywhere beyond.
        case ($urandom_range(0, 3))
          0: flen = LEN_MIN - 1;
          1: flen = $urandom_range(0, LEN_MIN - 1);
          2: flen = lim + 1;
          default: flen = $urandom_range(lim + 1, 255);
        endcase
        push_frame(hdr, flen, 8, 1'b0);
        done += 8;
      end else if (pick < 94) begin
        pick = $urandom_range(1, flen - 1);
        push_frame(hdr, flen, pick, 1'b0);
        done += pick;
      end else begin
        repeat ($urandom_range(1, 4)) stage_byte(8'($urandom));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic string rec_str(input frame_rec_t r);
    return $sformatf("%s type=%02h seq=%02h/%02h len=%0d crc=%04h data=%016h n=%0d last=%0d",
                     r.ev.name(), r.ftype, r.seq1, r.seq2, r.flen, r.crc, r.data,
                     r.nbytes, r.last);
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) $display("%0t: mismatch: %s", $time, what);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next byte word on rx, hold it until taken, and feed
  // every accepted byte to the shadow deframer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) deframe_byte(rx_byte_i);
      // Advance only when the current word went through or none is shown.
      if (!rx_valid_i || rx_ready_o) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_byte_i  <= rx_bytes_q.pop_front();
          rx_valid_i <= 1'b1;
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the out channel at random and check every result word
  // against the oldest one due.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_results
    frame_rec_t seen, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        seen = mk_rec(event_e'(event_res_o), frame_type_o, seq_first_o, seq_second_o,
                      frame_len_o, crc_calc_o, chunk_data_o, chunk_bytes_o, last_o);
        if (records_due.size() == 0) begin
          flag_mismatch({"word with nothing due: ", rec_str(seen)});
        end else begin
          want = records_due.pop_front();
          if (seen !== want)
            flag_mismatch({"expected ", rec_str(want), " got ", rec_str(seen)});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Hold the sender until every queued byte is taken and every result word
  // has come back, then let a byte that decided nothing finish inside.
  task automatic drain();
    while (rx_bytes_q.size() != 0 || rx_valid_i || records_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  // Put random junk in the upper data bits, which the block must drop.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HEADER) cfg_hdr = value;
    else cfg_maxlen = value;
  endtask

  task automatic run_phase(input logic [7:0] hdr, input logic [7:0] maxlen,
                           input int unsigned sidle, input int unsigned rstall,
                           input int unsigned quota);
    drain();
    write_reg(REG_HEADER, hdr);
    write_reg(REG_MAXLEN, maxlen);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    push_traffic(hdr, maxlen, quota);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at reset settings with no idling: noise at both byte extremes,
    // a frame of minimum length (header word only), a length one below the
    // minimum, and a frame whose payload ends in a one-byte chunk.
    stage_byte(8'h00);
    stage_byte(8'hFF);
    push_frame(cfg_hdr, LEN_MIN, LEN_MIN, 1'b0);
    push_frame(cfg_hdr, LEN_MIN - 1, 8, 1'b0);
    push_frame(cfg_hdr, LEN_MIN + 1, LEN_MIN + 1, 1'b0);

    // Random phases: header at both extremes, length limit at the minimum,
    // above the hard cap, below the minimum (all lengths bad) and in between.
    run_phase(8'h00, 8'd128, 49, 0, 90);
    run_phase(8'hFF, 8'd10, 0, 49, 60);
    run_phase(8'h5A, 8'd255, 7, 7, 90);
    run_phase(8'hA5, 8'd0, 0, 0, 30);
    run_phase(8'h3C, 8'd40, 0, 49, 80);

    drain();
    if (mismatch_cnt == 0) begin
      $display("[rx_frame_deframer_crc16] OK");
    end else begin
      $display("[rx_frame_deframer_crc16] ERROR");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #4000000;
    $display("[rx_frame_deframer_crc16] ERROR");
    $finish;
  end

endmodule
